// File: src/gtg_pkg.sv
// Shared types, constants and a blend helper function for the gradient texel generator.
package gtg_pkg;

  localparam int MAX_STOPS  = 8;
  localparam int TILE_SIZE  = 32;
  localparam int TILE_SHIFT = $clog2(TILE_SIZE);
  localparam int IDX_W      = $clog2(MAX_STOPS);
  localparam int CNT_W      = $clog2(MAX_STOPS + 1);
  localparam int RATIO_W    = 9;
  localparam int RATIO_ONE  = 256;
  localparam int X_W        = 5;
  localparam int DX_W       = X_W + 2;
  localparam int SQ_W       = $clog2(2 * TILE_SIZE * TILE_SIZE + 1);
  localparam int ROOT_W     = (SQ_W + 17) / 2;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int F_W        = ROOT_W - TILE_SHIFT;
  localparam int END_W      = TILE_SHIFT + 1;
  localparam int DIV_W      = 9;
  localparam int W_W        = 8;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         stop_slot;
    logic [RATIO_W-1:0] stop_ratio;
    logic [7:0]         stop_red;
    logic [7:0]         stop_green;
    logic [7:0]         stop_blue;
    logic [7:0]         stop_alpha;
    logic               final_stop;
    logic               radial_mode;
    logic [X_W-1:0]     texel_x;
    logic [X_W-1:0]     texel_y;
  } req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       empty_table;
  } res_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SKIP,
    OP_LINEAR,
    OP_RADIAL
  } op_e;

  // queue entry handed from front to back
  typedef struct packed {
    op_e                op;
    logic [3:0]         slot;
    logic [RATIO_W-1:0] ratio;
    logic [31:0]        colour;   // {A,B,G,R}
    logic               final_stop;
    logic [X_W-1:0]     x;
    logic [SQ_W-1:0]    sq;
  } qent_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [W_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] sq;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LREQ,
    ST_LCHK,
    ST_LFIN,
    ST_SQRT,
    ST_RREQ0,
    ST_RA,
    ST_RREQ,
    ST_RCHK,
    ST_RDEC,
    ST_DIV,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_OUT
  } st_e;

  // one channel of (a*(256-w) + b*w) >> 8, as a + ((b-a)*w >>> 8)
  function automatic logic [7:0] blend_ch(logic [7:0] a, logic [7:0] b, logic [W_W-1:0] w);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, w});
    acc  = $signed({2'b00, a, 8'h00}) + prod;
    return acc[15:8];
  endfunction

endpackage

// File: src/gtg_front.sv
// Front end: accepts items, classifies them and prepares queue entries.
module gtg_front
  import gtg_pkg::*;
(
  input  logic  start_i,
  input  req_t  req_i,
  input  logic  q_full_i,
  output logic  busy_o,
  output logic  push_o,
  output qent_t ent_o
);

  logic signed [DX_W-1:0]   dx, dy;
  logic signed [2*DX_W-1:0] dxx, dyy;
  logic [2*DX_W:0]          sum;

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  assign dx  = $signed({1'b0, req_i.texel_x, 1'b0}) - $signed(DX_W'(TILE_SIZE));
  assign dy  = $signed({1'b0, req_i.texel_y, 1'b0}) - $signed(DX_W'(TILE_SIZE));
  assign dxx = dx * dx;
  assign dyy = dy * dy;
  assign sum = {1'b0, dxx} + {1'b0, dyy};

  always_comb begin
    ent_o.slot       = {1'b0, req_i.stop_slot};
    ent_o.ratio      = (req_i.stop_ratio > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE)
                                                                : req_i.stop_ratio;
    ent_o.colour     = {req_i.stop_alpha, req_i.stop_blue, req_i.stop_green, req_i.stop_red};
    ent_o.final_stop = req_i.final_stop;
    ent_o.x          = req_i.texel_x;
    ent_o.sq         = SQ_W'(sum);
    if (!req_i.req_type) begin
      // slots past the table are dropped, final mark included
      ent_o.op = ({1'b0, req_i.stop_slot} >= 4'(MAX_STOPS)) ? OP_SKIP : OP_LOAD;
    end else if (req_i.radial_mode) begin
      ent_o.op = OP_RADIAL;
    end else begin
      ent_o.op = OP_LINEAR;
    end
  end

endmodule

// File: src/gtg_queue.sv
// Two-entry queue between front and back.
module gtg_queue
  import gtg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output qent_t ent_o
);

  qent_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign ent_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: src/gtg_div.sv
// Restoring divider: one quotient bit per cycle, numerator below denominator.
module gtg_div
  import gtg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W:0]     rem_q;
  logic [DIV_W-1:0]   den_q;
  logic [W_W-1:0]     quo_q;
  logic [3:0]         cnt_q;
  logic               run_q, done_q;
  logic [DIV_W+1:0]   shl;
  logic               ge;

  assign shl = {rem_q, 1'b0};
  assign ge  = shl >= (DIV_W+2)'(den_q);

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num};
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= ge ? (DIV_W+1)'(shl - (DIV_W+2)'(den_q)) : (DIV_W+1)'(shl);
      quo_q <= {quo_q[W_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= 4'(W_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/gtg_sqrt.sv
// Digit-by-digit integer square root of sq * 65536, one root bit per cycle.
module gtg_sqrt
  import gtg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  opd_q;
  logic [ROOT_W+2:0] rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q, done_q;
  logic [ROOT_W+2:0] rem_n, trial;
  logic              ge;

  assign rem_n = {rem_q[ROOT_W:0], opd_q[RAD_W-1 -: 2]};
  assign trial = (ROOT_W+3)'({root_q, 2'b01});
  assign ge    = rem_n >= trial;

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      opd_q  <= RAD_W'({req_i.sq, 16'h0000});
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      opd_q  <= {opd_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_n - trial : rem_n;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CW'(ROOT_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/gtg_back.sv
// Back end: stop table, stop search sequencer, colour fetch and blend.
module gtg_back
  import gtg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  qent_t     ent_i,
  output logic      pop_o,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output sqrt_req_t sqrt_req_o,
  input  sqrt_rsp_t sqrt_rsp_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  logic [RATIO_W-1:0] ratio_mem [MAX_STOPS];
  logic [31:0]        colour_mem [MAX_STOPS];
  logic [RATIO_W-1:0] ratio_rd_q;
  logic [31:0]        colour_rd_q;
  logic [IDX_W-1:0]   ratio_addr, colour_addr;
  logic               mem_we;

  st_e               st_q, st_d;
  logic [CNT_W-1:0]  total_q;
  logic [CNT_W-1:0]  idx_q, idx_p1;
  logic [X_W-1:0]    x_q;
  logic [END_W-1:0]  start_q, sstart_q, send_q, end_v;
  logic [CNT_W-1:0]  seg_q;
  logic              found_q, hit;
  logic [F_W-1:0]    f_q;
  logic [RATIO_W-1:0] ra_q, rb_q;
  logic [IDX_W-1:0]  ca_q, cb_q;
  logic [W_W-1:0]    w_q;
  logic [31:0]       col_a_q;
  logic              res_valid_q;
  res_t              res_q;

  logic              is_idle_pop, lin_last, r_adv;
  logic              rd_lo, rd_hi, rd_flat;

  assign idx_p1 = idx_q + 1'b1;
  assign end_v  = END_W'(({ratio_rd_q, {TILE_SHIFT{1'b0}}}) >> 8);
  assign hit    = (END_W'(x_q) >= start_q) && (END_W'(x_q) < end_v);
  assign lin_last = (END_W'(x_q) >= start_q) || (END_W'(x_q) >= END_W'(TILE_SIZE)) || !found_q;
  assign r_adv  = ((idx_q + CNT_W'(2)) < total_q) && (F_W'(ratio_rd_q) < f_q);
  assign rd_lo   = f_q <= F_W'(ra_q);
  assign rd_hi   = f_q >= F_W'(rb_q);
  assign rd_flat = rb_q <= ra_q;
  assign is_idle_pop = (st_q == ST_IDLE) && q_valid_i;

  // table memories, registered reads
  assign mem_we = is_idle_pop && (ent_i.op == OP_LOAD);
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ratio_mem[ent_i.slot[IDX_W-1:0]]  <= ent_i.ratio;
      colour_mem[ent_i.slot[IDX_W-1:0]] <= ent_i.colour;
    end
    ratio_rd_q  <= ratio_mem[ratio_addr];
    colour_rd_q <= colour_mem[colour_addr];
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (ent_i.op)
            OP_LINEAR: begin
              if (total_q == '0)      st_d = ST_IDLE;
              else if (total_q == 1)  st_d = ST_FETCH_A;
              else                    st_d = ST_LREQ;
            end
            OP_RADIAL: begin
              if (total_q == '0)      st_d = ST_IDLE;
              else if (total_q == 1)  st_d = ST_FETCH_A;
              else                    st_d = ST_SQRT;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_LREQ:    st_d = ST_LCHK;
      ST_LCHK:    st_d = (idx_p1 == total_q) ? ST_LFIN : ST_LREQ;
      ST_LFIN:    st_d = lin_last ? ST_FETCH_A : ST_DIV;
      ST_SQRT:    st_d = sqrt_rsp_i.done ? ST_RREQ0 : ST_SQRT;
      ST_RREQ0:   st_d = ST_RA;
      ST_RA:      st_d = ST_RREQ;
      ST_RREQ:    st_d = ST_RCHK;
      ST_RCHK:    st_d = r_adv ? ST_RREQ : ST_RDEC;
      ST_RDEC:    st_d = (rd_lo || rd_hi || rd_flat) ? ST_FETCH_A : ST_DIV;
      ST_DIV:     st_d = div_rsp_i.done ? ST_FETCH_A : ST_DIV;
      ST_FETCH_A: st_d = ST_FETCH_B;
      ST_FETCH_B: st_d = ST_OUT;
      ST_OUT:     st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o            = is_idle_pop;
    ratio_addr       = idx_q[IDX_W-1:0];
    colour_addr      = ca_q;
    div_req_o.start  = 1'b0;
    div_req_o.num    = '0;
    div_req_o.den    = '0;
    sqrt_req_o.start = 1'b0;
    sqrt_req_o.sq    = ent_i.sq;
    case (st_q)
      ST_IDLE: begin
        sqrt_req_o.start = q_valid_i && (ent_i.op == OP_RADIAL) && (total_q > 1);
      end
      ST_RREQ0:   ratio_addr = '0;
      ST_RREQ:    ratio_addr = idx_p1[IDX_W-1:0];
      ST_LFIN: begin
        div_req_o.start = !lin_last;
        div_req_o.num   = DIV_W'(END_W'(x_q) - sstart_q);
        div_req_o.den   = DIV_W'(send_q - sstart_q);
      end
      ST_RDEC: begin
        div_req_o.start = !(rd_lo || rd_hi || rd_flat);
        div_req_o.num   = DIV_W'(f_q - F_W'(ra_q));
        div_req_o.den   = DIV_W'(rb_q - ra_q);
      end
      ST_FETCH_B: colour_addr = cb_q;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        x_q     <= ent_i.x;
        idx_q   <= CNT_W'(1);
        start_q <= '0;
        w_q     <= '0;
        ca_q    <= '0;
        cb_q    <= '0;
      end
      ST_LCHK: begin
        if (hit) begin
          seg_q    <= idx_q;
          sstart_q <= start_q;
          send_q   <= end_v;
        end
        start_q <= end_v;
        idx_q   <= idx_p1;
      end
      ST_LFIN: begin
        if (lin_last) begin
          ca_q <= IDX_W'(total_q - 1'b1);
          cb_q <= IDX_W'(total_q - 1'b1);
        end else begin
          ca_q <= IDX_W'(seg_q - 1'b1);
          cb_q <= IDX_W'(seg_q);
        end
      end
      ST_SQRT: begin
        f_q   <= F_W'(sqrt_rsp_i.root >> TILE_SHIFT);
        idx_q <= '0;
      end
      ST_RA: ra_q <= ratio_rd_q;
      ST_RCHK: begin
        if (r_adv) begin
          ra_q  <= ratio_rd_q;
          idx_q <= idx_p1;
        end else begin
          rb_q <= ratio_rd_q;
        end
      end
      ST_RDEC: begin
        // at or below the start: start colour; at or past the end: end colour
        if (rd_lo) begin
          ca_q <= IDX_W'(idx_q);
          cb_q <= IDX_W'(idx_q);
        end else if (rd_hi) begin
          ca_q <= IDX_W'(idx_p1);
          cb_q <= IDX_W'(idx_p1);
        end else if (rd_flat) begin
          ca_q <= IDX_W'(idx_q);
          cb_q <= IDX_W'(idx_q);
        end else begin
          ca_q <= IDX_W'(idx_q);
          cb_q <= IDX_W'(idx_p1);
        end
      end
      ST_DIV:     w_q <= div_rsp_i.quo;
      ST_FETCH_B: col_a_q <= colour_rd_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      total_q <= '0;
      found_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (mem_we && ent_i.final_stop) total_q <= CNT_W'(ent_i.slot + 1'b1);
      if (st_q == ST_IDLE)                found_q <= 1'b0;
      else if (st_q == ST_LCHK && hit)    found_q <= 1'b1;
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (st_q == ST_OUT) ||
                     (is_idle_pop && total_q == '0 &&
                      (ent_i.op == OP_LINEAR || ent_i.op == OP_RADIAL));
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_OUT) begin
      res_q.out_red     <= blend_ch(col_a_q[7:0],   colour_rd_q[7:0],   w_q);
      res_q.out_green   <= blend_ch(col_a_q[15:8],  colour_rd_q[15:8],  w_q);
      res_q.out_blue    <= blend_ch(col_a_q[23:16], colour_rd_q[23:16], w_q);
      res_q.out_alpha   <= blend_ch(col_a_q[31:24], colour_rd_q[31:24], w_q);
      res_q.empty_table <= 1'b0;
    end else if (st_q == ST_IDLE) begin
      res_q <= '{out_red: 8'h00, out_green: 8'h00, out_blue: 8'h00, out_alpha: 8'h00,
                 empty_table: 1'b1};
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: src/gradient_texel_generator_core.sv
// Top level of the gradient texel generator: front end, queue, back end and arithmetic units.
//
// Items enter on start_i while busy_o is low and land in a two-entry queue; busy_o is high
// only while that queue is full. Load transactions write one colour stop (ratio above 1.0
// is stored as 1.0) and produce no result; a load with final_stop set makes the stop count
// slot plus one. Query transactions return one texel, RGBA, on result_o for exactly one
// cycle with result_valid_o high; the receiver cannot stall, so it must take every strobe.
// Transactions complete strictly in order and the back end works on one at a time.
// A load is written into the stop table as the back end pops it. A query on an empty
// table is answered from the idle state with empty_table set; a single-stop table goes
// straight to the two colour fetches. A linear query scans each stop after the first with
// a read request and a check state, then fetches the last colour when the texel lies past
// the last segment end or in no segment, or else runs the 8-step weight divider and blends.
// A radial query runs the bit-serial square root, fetches the first two ratios, searches
// the stops one read at a time, then either takes a clamped colour or runs the divider and
// blends. Each table read is registered, so every stop read and each of the two colour
// fetches has its own request state.
module gradient_texel_generator_core
  import gtg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic result_valid_o,
  output res_t result_o
);

  logic      q_full, q_valid, push, pop;
  qent_t     ent_in, ent_out;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  gtg_front u_front (
    .start_i  (start_i),
    .req_i    (req_i),
    .q_full_i (q_full),
    .busy_o   (busy_o),
    .push_o   (push),
    .ent_o    (ent_in)
  );

  gtg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .ent_o   (ent_out)
  );

  gtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gtg_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  gtg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .ent_i       (ent_out),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .sqrt_req_o  (sqrt_req),
    .sqrt_rsp_i  (sqrt_rsp),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

// File: tb/testbench.sv
// Testbench for the gradient texel generator core: directed and random load/query checks.
`timescale 1ns / 1ps

module testbench;
  import gtg_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic result_valid_o;
  res_t result_o;

  gradient_texel_generator_core i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .req_i(req_i),
    .busy_o(busy_o),
    .result_valid_o(result_valid_o),
    .result_o(result_o)
  );

  // predictor state: shadow of the stop table
  logic [8:0]  ratio_tab  [MAX_STOPS];
  logic [31:0] colour_tab [MAX_STOPS];
  logic [3:0]  stop_cnt;
  logic [MAX_STOPS-1:0] written;

  res_t texel_q[$];
  int   err_cnt;
  int   idle_cycles;
  int   send_idle_pct;

  localparam bit REQ_LOAD  = 1'b0;
  localparam bit REQ_QUERY = 1'b1;
  localparam bit MODE_LIN  = 1'b0;
  localparam bit MODE_RAD  = 1'b1;
  localparam int WATCHDOG  = 2000;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic logic [31:0] mix_rgba(logic [31:0] ca, logic [31:0] cb, int w);
    logic [31:0] res;
    int a, b;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      a = (ca >> (8 * k)) & 8'hff;
      b = (cb >> (8 * k)) & 8'hff;
      res |= (((a * (256 - w) + b * w) >> 8) & 8'hff) << (8 * k);
    end
    return res;
  endfunction

  function automatic int root_floor(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return int'(r);
  endfunction

  function automatic logic [31:0] ramp_linear(int n, int x);
    int s, e, w;
    bit hit;
    logic [31:0] c;
    s = 0;
    hit = 0;
    c = colour_tab[n - 1];
    for (int i = 1; i < n; i++) begin
      e = ratio_tab[i] * TILE_SIZE / 256;
      if (x >= s && x < e) begin
        w = (x - s) * 256 / (e - s);
        c = mix_rgba(colour_tab[i - 1], colour_tab[i], w);
        hit = 1;
      end
      s = e;
    end
    if (x >= s || x >= TILE_SIZE || !hit) c = colour_tab[n - 1];
    return c;
  endfunction

  function automatic logic [31:0] ramp_radial(int n, int x, int y);
    int dx, dy, f, i, ra, rb;
    dx = 2 * x - TILE_SIZE;
    dy = 2 * y - TILE_SIZE;
    f = root_floor(longint'(dx * dx + dy * dy) * 65536) / TILE_SIZE;
    if (n <= 1) return colour_tab[0];
    i = 0;
    while (i + 2 < n && ratio_tab[i + 1] < f) i++;
    ra = ratio_tab[i];
    rb = ratio_tab[i + 1];
    if (f <= ra) return colour_tab[i];
    if (f >= rb) return colour_tab[i + 1];
    if (rb <= ra) return colour_tab[i];
    return mix_rgba(colour_tab[i], colour_tab[i + 1], (f - ra) * 256 / (rb - ra));
  endfunction

  // update shadow table on a load, queue the expected texel on a query
  task automatic predict_texel(input req_t r);
    res_t t;
    logic [31:0] c;
    int n;
    if (r.req_type == REQ_LOAD) begin
      ratio_tab[r.stop_slot]  = (r.stop_ratio > 256) ? 9'd256 : r.stop_ratio;
      colour_tab[r.stop_slot] = {r.stop_alpha, r.stop_blue, r.stop_green, r.stop_red};
      written[r.stop_slot]    = 1'b1;
      if (r.final_stop) stop_cnt = 4'(r.stop_slot) + 4'd1;
      return;
    end
    n = stop_cnt;
    t = '0;
    if (n == 0) begin
      t.empty_table = 1'b1;
    end else begin
      c = r.radial_mode ? ramp_radial(n, r.texel_x, r.texel_y) : ramp_linear(n, r.texel_x);
      t.out_red   = c[7:0];
      t.out_green = c[15:8];
      t.out_blue  = c[23:16];
      t.out_alpha = c[31:24];
    end
    texel_q.push_back(t);
  endtask

  // one transaction; start stays high across back-to-back sends and is dropped by the
  // idle loop of the next send or by wait_drain
  task automatic send_item(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_texel(r);
  endtask

  // result checker; the receiver cannot stall
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (texel_q.size() == 0) begin
        report_mismatch("unexpected texel", 1, 0);
      end else begin
        res_t w;
        w = texel_q.pop_front();
        if (result_o.out_red !== w.out_red) report_mismatch("red", result_o.out_red, w.out_red);
        if (result_o.out_green !== w.out_green)
          report_mismatch("green", result_o.out_green, w.out_green);
        if (result_o.out_blue !== w.out_blue)
          report_mismatch("blue", result_o.out_blue, w.out_blue);
        if (result_o.out_alpha !== w.out_alpha)
          report_mismatch("alpha", result_o.out_alpha, w.out_alpha);
        if (result_o.empty_table !== w.empty_table)
          report_mismatch("empty", result_o.empty_table, w.empty_table);
      end
    end
  end

  // watchdog: cycles with no accepted transaction and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic req_t make_load(int slot, int ratio, logic [31:0] c, bit fin);
    req_t r;
    r = req_t'($bits(req_t)'({$urandom, $urandom}));
    r.req_type   = REQ_LOAD;
    r.stop_slot  = 3'(slot);
    r.stop_ratio = RATIO_W'(ratio);
    {r.stop_alpha, r.stop_blue, r.stop_green, r.stop_red} = c;
    r.final_stop = fin;
    return r;
  endfunction

  function automatic req_t make_query(bit radial, int x, int y);
    req_t r;
    r = req_t'($bits(req_t)'({$urandom, $urandom}));
    r.req_type    = REQ_QUERY;
    r.radial_mode = radial;
    r.texel_x     = X_W'(x);
    r.texel_y     = X_W'(y);
    return r;
  endfunction

  task automatic wait_drain();
    start_i <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk_i);
  endtask

  // loads a full gradient of n stops with ascending (mostly) random ratios
  task automatic load_gradient(input int n);
    int rat;
    rat = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) rat = $urandom_range(511);
      else if (i > 0) rat = rat + $urandom_range(512 / n);
      send_item(make_load(i, (i == 0 && $urandom_range(1)) ? 0 : rat, $urandom, i == n - 1));
    end
  endtask

  task automatic test_empty_table();
    send_item(make_query(MODE_LIN, 0, 0));
    send_item(make_query(MODE_RAD, 31, 31));
  endtask

  task automatic test_directed();
    // single stop: every texel takes its colour
    send_item(make_load(0, 511, 32'hffffffff, 1'b1));
    send_item(make_query(MODE_LIN, 31, 0));
    send_item(make_query(MODE_RAD, 16, 16));
    // two stops with extreme ratios, and ratio above 1.0 clamps
    send_item(make_load(0, 0, 32'h00000000, 1'b0));
    send_item(make_load(1, 300, 32'hffffffff, 1'b1));
    send_item(make_query(MODE_LIN, 0, 0));
    send_item(make_query(MODE_LIN, 17, 0));
    send_item(make_query(MODE_RAD, 0, 0));
    send_item(make_query(MODE_RAD, 16, 16));
    // zero-width segment
    send_item(make_load(1, 0, 32'h12345678, 1'b1));
    send_item(make_query(MODE_RAD, 20, 9));
    send_item(make_query(MODE_LIN, 5, 0));
    // full table of eight stops
    load_gradient(MAX_STOPS);
    send_item(make_query(MODE_LIN, 31, 31));
    send_item(make_query(MODE_RAD, 31, 0));
    send_item(make_query(MODE_LIN, 13, 0));
    wait_drain();
  endtask

  task automatic test_random(input int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        // noise: single stray load into an already written slot
        n = $urandom_range(MAX_STOPS - 1);
        if (written[n]) begin
          send_item(make_load(n, $urandom_range(511), $urandom, 1'b0));
          sent++;
        end
      end else begin
        n = $urandom_range(MAX_STOPS, 1);
        if ($urandom_range(3) == 0) n = $urandom_range(2, 1);
        load_gradient(n);
        sent += n;
        repeat ($urandom_range(8, 2)) begin
          send_item(make_query(1'($urandom_range(1)), $urandom_range(31), $urandom_range(31)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    err_cnt = 0;
    idle_cycles = 0;
    stop_cnt = 0;
    written = '0;
    send_idle_pct = 36;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed();
    test_random(350);
    wait_drain();
    send_idle_pct = 60;
    test_random(350);
    send_idle_pct = 0;
    test_random(350);

    wait_drain();
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0 && texel_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
